// ===== hdl/assert_macros.svh =====
// Assertion macros for the replacement engine.
// Needs nothing else; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hdl/ddsr_pkg.sv =====
// Package for the replacement engine: field widths, defaults, codes and states.
// Depends on nothing.
package ddsr_pkg;

  localparam int DefNumSets     = 2048;
  localparam int DefNumWays     = 16;
  localparam int DefLeaderCount = 64;
  localparam int DefSelBits     = 10;

  localparam int SetIdxW  = 11;
  localparam int MaskW    = 16;
  localparam int WayIdxW  = 4;
  localparam int AddrW    = 48;
  localparam int RandW    = 5;
  localparam int PselOutW = 10;
  localparam int LevelW   = 2;

  localparam int StrideOne = 64;
  localparam int StrideTwo = 128;
  localparam int LineBytes = 64;

  localparam logic [1:0] RrpvNear    = 2'd0;
  localparam logic [1:0] RrpvLong    = 2'd2;
  localparam logic [1:0] RrpvDistant = 2'd3;
  localparam logic [1:0] StreamStrong = 2'd2;

  localparam logic CmdVictim = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_NEG
  } state_e;

endpackage

// ===== hdl/drrip_deadblock_stream_replacement_top.sv =====
// Replacement engine top level: set metadata memory, sequencer and shared subtractor.
// Depends on ddsr_pkg and assert_macros.svh.
//
//  channel  | handshake        | words
//  ---------+------------------+-----------------------------------------------
//  request  | start_i, busy_o  | cmd, set, valid mask, way, address, hit, random
//  result   | done_o strobe    | victim way, selector value, stream level
//
// A request is taken when start_i is high and busy_o low. A victim request, an
// out-of-range set or an update whose address is not below the stored one ends
// in the execute step; else the shared 48-bit subtractor runs a second pass.
// The result strobe follows in the cycle after the last step, one cycle wide.
// After reset a clearing pass writes all NUM_SETS rows, one per cycle, busy high.
// The receiver cannot stall; results are never held back.
`include "assert_macros.svh"

module drrip_deadblock_stream_replacement_top
  import ddsr_pkg::*;
#(
  parameter int NUM_SETS      = DefNumSets,
  parameter int NUM_WAYS      = DefNumWays,
  parameter int LEADER_COUNT  = DefLeaderCount,
  parameter int SELECTOR_BITS = DefSelBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                cmd_i,
  input  logic [SetIdxW-1:0]  set_index_i,
  input  logic [MaskW-1:0]    valid_mask_i,
  input  logic [WayIdxW-1:0]  way_index_i,
  input  logic [AddrW-1:0]    phys_addr_i,
  input  logic                is_hit_i,
  input  logic [RandW-1:0]    random_bits_i,
  output logic                done_o,
  output logic [WayIdxW-1:0]  victim_way_o,
  output logic [PselOutW-1:0] psel_value_o,
  output logic [LevelW-1:0]   stream_level_o
);

  localparam int SetW   = $clog2(NUM_SETS);
  localparam int IdxW   = (SetW > SetIdxW) ? SetW : SetIdxW;
  localparam int DeadLo = 2 * NUM_WAYS;
  localparam int ScLo   = 3 * NUM_WAYS;
  localparam int AddrLo = ScLo + 2;
  localparam int RowW   = AddrLo + AddrW;
  localparam int PselW  = (SELECTOR_BITS > PselOutW) ? SELECTOR_BITS : PselOutW;
  localparam logic [SELECTOR_BITS-1:0] SelMid = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
  localparam logic [SELECTOR_BITS-1:0] SelMax = SELECTOR_BITS'((1 << SELECTOR_BITS) - 1);
  localparam logic [AddrW-1:0] FarDelta = AddrW'(LineBytes * NUM_WAYS);

  logic [RowW-1:0] mem_q [NUM_SETS];
  logic [RowW-1:0] rd_q;

  state_e state_q, state_d;
  logic [SetW-1:0] clr_q, clr_d;
  logic [SELECTOR_BITS-1:0] psel_q, psel_d;
  logic done_q;
  logic [WayIdxW-1:0] victim_q, victim_d;
  logic [LevelW-1:0] level_q, level_d;

  logic              cmd_q, hit_q, in_range_q, srrip_q, brrip_q;
  logic [IdxW-1:0]   set_q;
  logic [MaskW-1:0]  mask_q;
  logic [WayIdxW-1:0] way_q;
  logic [AddrW-1:0]  addr_q;
  logic [RandW-1:0]  rnd_q;

  logic [IdxW-1:0] set_ext;
  logic accept, finish, need_neg, clr_we;
  logic [RowW-1:0] row_d, row_rst;

  logic [AddrW-1:0] prev, sub_a, sub_b, delta;
  logic [AddrW:0]   sub_res;
  logic             borrow;

  assign set_ext = IdxW'(set_index_i);
  assign accept  = start_i && !busy_o;

  assign prev    = rd_q[AddrLo +: AddrW];
  assign sub_a   = (state_q == S_NEG) ? prev : addr_q;
  assign sub_b   = (state_q == S_NEG) ? addr_q : prev;
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[AddrW];
  assign delta   = (prev == '0) ? '0 : sub_res[AddrW-1:0];
  assign need_neg = in_range_q && (cmd_q == CmdUpdate) && (prev != '0) && borrow;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SetW'(NUM_SETS - 1)) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_EXEC;
      S_EXEC:  state_d = need_neg ? S_NEG : S_IDLE;
      S_NEG:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b1;
    clr_we = 1'b0;
    finish = 1'b0;
    clr_d  = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      S_IDLE:  busy_o = 1'b0;
      S_EXEC:  finish = !need_neg;
      S_NEG:   finish = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_comb begin
    logic [1:0] rrpv [NUM_WAYS];
    logic [1:0] maxv, sc_old, sc_new, ins;
    logic       brrip_pick, way_ok, is_inv;
    logic       inv_hit, dead_hit;
    logic [WayIdxW-1:0] inv_way, dead_way, age_way;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv[w] = rd_q[2*w +: 2];
    end
    sc_old = rd_q[ScLo +: 2];
    row_rst = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_rst[2*w +: 2]  = RrpvLong;
      row_rst[DeadLo + w] = 1'b1;
    end

    inv_hit = 1'b0;
    dead_hit = 1'b0;
    inv_way = '0;
    dead_way = '0;
    age_way = '0;
    maxv = 2'd0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      is_inv = (w >= MaskW) ? 1'b1 : !mask_q[w % MaskW];
      if (is_inv) begin
        inv_hit = 1'b1;
        inv_way = WayIdxW'(w);
      end
      if (rd_q[DeadLo + w]) begin
        dead_hit = 1'b1;
        dead_way = WayIdxW'(w);
      end
      if (rrpv[w] > maxv) maxv = rrpv[w];
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rrpv[w] == maxv) age_way = WayIdxW'(w);
    end

    sc_new = sc_old;
    if (delta == AddrW'(StrideOne) || delta == AddrW'(StrideTwo)) begin
      if (sc_old < StreamStrong) sc_new = sc_old + 2'd1;
    end else if (delta > FarDelta) begin
      if (sc_old > 2'd0) sc_new = sc_old - 2'd1;
    end

    if (srrip_q) brrip_pick = 1'b0;
    else if (brrip_q) brrip_pick = 1'b1;
    else brrip_pick = psel_q < SelMid;

    if (sc_new >= StreamStrong) ins = RrpvDistant;
    else if (!brrip_pick) ins = RrpvLong;
    else ins = (rnd_q == '0) ? RrpvLong : RrpvDistant;

    way_ok = 6'(way_q) < 6'(NUM_WAYS);
    row_d = rd_q;
    victim_d = '0;
    psel_d = psel_q;
    level_d = '0;
    if (in_range_q) begin
      if (cmd_q == CmdVictim) begin
        level_d = sc_old;
        if (inv_hit) victim_d = inv_way;
        else if (dead_hit) victim_d = dead_way;
        else begin
          victim_d = age_way;
          for (int w = 0; w < NUM_WAYS; w++) begin
            row_d[2*w +: 2] = rrpv[w] + (RrpvDistant - maxv);
          end
        end
      end else begin
        level_d = sc_new;
        row_d[ScLo +: 2] = sc_new;
        row_d[AddrLo +: AddrW] = addr_q;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (way_ok && w == int'(way_q)) begin
            row_d[2*w +: 2]   = hit_q ? RrpvNear : ins;
            row_d[DeadLo + w] = !hit_q;
          end
        end
        if (hit_q) begin
          if (srrip_q && psel_q < SelMax) psel_d = psel_q + 1'b1;
          else if (brrip_q && psel_q > '0) psel_d = psel_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      mem_q[clr_q] <= row_rst;
    end else if (finish && in_range_q) begin
      mem_q[set_q[SetW-1:0]] <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[set_ext[SetW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      set_q      <= set_ext;
      in_range_q <= (IdxW+1)'(set_ext) < (IdxW+1)'(NUM_SETS);
      srrip_q    <= set_ext < IdxW'(LEADER_COUNT);
      brrip_q    <= !(set_ext < IdxW'(LEADER_COUNT)) && (set_ext < IdxW'(2 * LEADER_COUNT));
      mask_q     <= valid_mask_i;
      way_q      <= way_index_i;
      addr_q     <= phys_addr_i;
      hit_q      <= is_hit_i;
      rnd_q      <= random_bits_i;
    end
    if (finish) begin
      victim_q <= victim_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      psel_q  <= SelMid;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= finish;
      if (finish) psel_q <= psel_d;
    end
  end

  logic [PselW-1:0] psel_ext;
  assign psel_ext       = PselW'(psel_q);
  assign done_o         = done_q;
  assign victim_way_o   = victim_q;
  assign psel_value_o   = psel_ext[PselOutW-1:0];
  assign stream_level_o = level_q;

  `ASSERT_CLK(a_accept_to_exec, accept |=> state_q == S_EXEC, "accepted word did not start")
  `ASSERT_CLK(a_neg_after_update, state_q == S_NEG |-> $past(state_q) == S_EXEC && cmd_q == CmdUpdate, "second subtractor pass without an update")
  `ASSERT_CLK(a_done_when_idle, done_o |-> !busy_o, "result word shown while busy")
  `ASSERT_CLK(a_psel_only_at_finish, $past(!finish) |-> $stable(psel_q), "selector moved outside a finish step")
  `ASSERT_NEVER(a_clear_then_done, state_q == S_CLEAR && done_o, "result word during clearing pass")

endmodule
